>>> src/gas_sensor_ppm_calibrated_top_macros.svh
// Assertion macros for the checker file of the gas sensor block
`ifndef GAS_SENSOR_PPM_CALIBRATED_TOP_MACROS_SVH
`define GAS_SENSOR_PPM_CALIBRATED_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, off while in reset
`define GSPC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset
`define GSPC_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/gspc_pkg.sv
// Shared constants, register codes and the exp2 root table of the gas sensor block
package gspc_pkg;

    // Default parameter values
    localparam int BATCH_LEN_DEF = 50;
    localparam int ADC_BITS_DEF  = 12;

    // Fixed widths
    localparam int SUM_W      = 18;
    localparam int CNT_W      = 6;
    localparam int VAL_W      = 18;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;
    localparam int DIV_N_W    = 48;
    localparam int DIV_D_W    = 32;
    localparam int ROOT_STEPS = 16;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LOAD  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EXP   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CLEAN = 2'd3;

    // Reset values
    localparam logic [15:0] LOAD_RESET  = 16'd2560;
    localparam logic [23:0] SCALE_RESET = 24'd28280;
    localparam logic [15:0] EXP_RESET   = 16'(65536 - 11723);
    localparam logic [15:0] CLEAN_RESET = 16'd922;
    localparam logic [31:0] REF_RESET   = 32'd1272709;

    typedef logic [31:0] root_tab_t [ROOT_STEPS];

    // Integer square root, evaluated at elaboration only
    function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] r;
        logic [63:0] b;
        v = v_in;
        r = '0;
        b = 64'd1 << 62;
        for (int i = 0; i < 32; i++)
        begin
            if (b > v)
            begin
                b = b >> 2;
            end
        end
        for (int i = 0; i < 32; i++)
        begin
            if (b != 64'd0)
            begin
                if (v >= r + b)
                begin
                    v = v - (r + b);
                    r = (r >> 1) + b;
                end
                else
                begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
        end
        return r;
    endfunction

    // Successive square roots of 2 in Q2.30, truncated at each step
    function automatic root_tab_t exp_roots();
        root_tab_t   t;
        logic [63:0] r;
        r = 64'd1 << 31;
        for (int k = 0; k < ROOT_STEPS; k++)
        begin
            r = isqrt64(r << 30);
            t[k] = r[31:0];
        end
        return t;
    endfunction

    localparam root_tab_t EXP_ROOT = exp_roots();

endpackage

>>> src/gas_sensor_ppm_calibrated_top.sv
// Gas sensor concentration block: calibration averaging and power-law ppm sequencer
//
// One transaction in, one transaction out. A calibration sample that does not close a
// batch only updates the running sum and count. The sample that closes a batch forms
// the average with one reciprocal multiply, then runs two passes of the shared 48-step
// restoring divider (sensor resistance, reference); a zero average skips both passes.
// A measure sample runs two divider passes, a normalising shift, 16 squaring steps of
// log2, 16 root-multiply steps of exp2 and a scale/shift tail; a zero reading skips
// them all. in_stall stays high while an item is in flight; a finished result waits in
// the output register and the next item may be taken then.
module gas_sensor_ppm_calibrated_top #(
    parameter int BATCH_LEN = gspc_pkg::BATCH_LEN_DEF,
    parameter int ADC_BITS  = gspc_pkg::ADC_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // configuration
    input  logic                           cfg_we,
    input  logic [gspc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [gspc_pkg::CFG_DATA_W-1:0] cfg_data,
    // input channel
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           cmd,
    input  logic [ADC_BITS-1:0]            sample,
    input  logic                           conversion_ok,
    // output channel
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [ADC_BITS-1:0]            raw_out,
    output logic [15:0]                    ppm,
    output logic                           calibration_done,
    output logic [31:0]                    reference_q16
);

    localparam int SUM_W   = gspc_pkg::SUM_W;
    localparam int CNT_W   = gspc_pkg::CNT_W;
    localparam int VAL_W   = gspc_pkg::VAL_W;
    localparam int DIV_N_W = gspc_pkg::DIV_N_W;
    localparam int DIV_D_W = gspc_pkg::DIV_D_W;

    localparam logic [VAL_W-1:0] FULL_V   = VAL_W'((1 << ADC_BITS) - 1);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(BATCH_LEN);
    localparam logic [5:0]       DIV_LAST = 6'(DIV_N_W - 1);
    localparam logic [5:0]       ITER_LAST = 6'(gspc_pkg::ROOT_STEPS - 1);
    // ceil(2^24 / batch length); exact floor average for any 18-bit sum
    localparam logic [23:0]      AVG_RECIP = 24'(((1 << 24) + BATCH_LEN - 1) / BATCH_LEN);

    // Sequencer states
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_RSMUL = 4'd1;
    localparam logic [3:0] S_DIV   = 4'd2;
    localparam logic [3:0] S_DVEND = 4'd3;
    localparam logic [3:0] S_NORM  = 4'd4;
    localparam logic [3:0] S_LOG   = 4'd5;
    localparam logic [3:0] S_YMUL  = 4'd6;
    localparam logic [3:0] S_EXP   = 4'd7;
    localparam logic [3:0] S_SCALE = 4'd8;
    localparam logic [3:0] S_SHIFT = 4'd9;
    localparam logic [3:0] S_FIN   = 4'd10;
    localparam logic [3:0] S_AVG   = 4'd11;

    // What the divider is working on
    localparam logic [1:0] DK_RS    = 2'd1;
    localparam logic [1:0] DK_R0    = 2'd2;
    localparam logic [1:0] DK_RATIO = 2'd3;

    // Configuration registers
    logic [15:0]        load_reg;
    logic [23:0]        scale_reg;
    logic signed [15:0] exp_reg;
    logic [15:0]        clean_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_reg  <= gspc_pkg::LOAD_RESET;
            scale_reg <= gspc_pkg::SCALE_RESET;
            exp_reg   <= gspc_pkg::EXP_RESET;
            clean_reg <= gspc_pkg::CLEAN_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                gspc_pkg::CFG_LOAD:  load_reg  <= cfg_data[15:0];
                gspc_pkg::CFG_SCALE: scale_reg <= cfg_data[23:0];
                gspc_pkg::CFG_EXP:   exp_reg   <= cfg_data[15:0];
                gspc_pkg::CFG_CLEAN: clean_reg <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Sequencer and datapath registers
    logic [3:0]           state_reg,  state_next;
    logic                 cmd_reg,    cmd_next;
    logic [ADC_BITS-1:0]  raw_reg,    raw_next;
    logic [VAL_W-1:0]     val_reg,    val_next;
    logic [SUM_W-1:0]     sum_reg,    sum_next;
    logic [CNT_W-1:0]     cnt_reg,    cnt_next;
    logic [31:0]          ref_reg,    ref_next;
    logic                 done_reg,   done_next;
    logic [15:0]          res_reg,    res_next;
    logic [DIV_N_W-1:0]   num_reg,    num_next;
    logic [DIV_D_W:0]     rem_reg,    rem_next;
    logic [DIV_D_W-1:0]   dsr_reg,    dsr_next;
    logic [1:0]           dk_reg,     dk_next;
    logic [5:0]           step_reg,   step_next;
    logic [31:0]          m_reg,      m_next;
    logic [4:0]           p_reg,      p_next;
    logic [15:0]          frac_reg,   frac_next;
    logic signed [24:0]   y_reg,      y_next;
    logic [30:0]          acc_reg,    acc_next;
    logic [54:0]          prod_reg,   prod_next;
    logic                 ovalid_reg, ovalid_next;
    logic [ADC_BITS-1:0]  oraw_reg,   oraw_next;
    logic [15:0]          oppm_reg,   oppm_next;
    logic                 odone_reg,  odone_next;
    logic [31:0]          oref_reg,   oref_next;

    // Combinational helpers
    logic                 accept;
    logic [ADC_BITS-1:0]  raw_in;
    logic [SUM_W-1:0]     sum_add;
    logic [CNT_W-1:0]     cnt_add;
    logic [SUM_W+23:0]    avg_prod;
    logic [VAL_W-1:0]     avg_val;
    logic [ADC_BITS-1:0]  diff;
    logic [15+ADC_BITS:0] rs_prod;
    logic [DIV_D_W:0]     rem_sh;
    logic                 q_bit;
    logic [31:0]          q_sat;
    logic [63:0]          sq;
    logic [32:0]          sq_t;
    logic signed [20:0]   log_s;
    logic signed [36:0]   ye_prod;
    logic [15:0]          f_bits;
    logic [62:0]          root_prod;
    logic signed [8:0]    ip;
    logic signed [9:0]    sh;
    logic [54:0]          shifted;
    logic                 out_load;

    assign accept = in_valid && !in_stall;
    assign raw_in = conversion_ok ? sample : '0;
    assign sum_add = sum_reg + SUM_W'(raw_in);
    assign cnt_add = cnt_reg + CNT_W'(1);

    // Batch average by reciprocal multiplication
    assign avg_prod = num_reg[SUM_W-1:0] * AVG_RECIP;
    assign avg_val  = avg_prod[SUM_W+23:24];

    // Sensor resistance numerator: load * (full - value), zero at or above full scale
    assign diff    = (val_reg >= FULL_V) ? '0 : ADC_BITS'(FULL_V - val_reg);
    assign rs_prod = load_reg * diff;

    // One restoring divider step
    assign rem_sh = {rem_reg[DIV_D_W-1:0], num_reg[DIV_N_W-1]};
    assign q_bit  = rem_sh >= {1'b0, dsr_reg};
    assign q_sat  = (|num_reg[DIV_N_W-1:32]) ? 32'hFFFF_FFFF : num_reg[31:0];

    // log2 squaring step
    assign sq   = m_reg * m_reg;
    assign sq_t = sq[63:31];

    // Exponent product: log2 value is {p - 16, fraction}
    assign log_s   = {~p_reg[4], p_reg[3:0], frac_reg};
    assign ye_prod = log_s * exp_reg;

    // exp2 root multiply
    assign f_bits    = y_reg[15:0];
    assign root_prod = acc_reg * gspc_pkg::EXP_ROOT[step_reg[3:0]];

    // Final shift and saturation
    assign ip      = y_reg[24:16];
    assign sh      = 10'sd38 - 10'(ip);
    assign shifted = prod_reg >> sh[5:0];

    assign out_load = (state_reg == S_FIN) && (!ovalid_reg || !out_stall);

    always_comb
    begin
        state_next  = state_reg;
        cmd_next    = cmd_reg;
        raw_next    = raw_reg;
        val_next    = val_reg;
        sum_next    = sum_reg;
        cnt_next    = cnt_reg;
        ref_next    = ref_reg;
        done_next   = done_reg;
        res_next    = res_reg;
        num_next    = num_reg;
        rem_next    = rem_reg;
        dsr_next    = dsr_reg;
        dk_next     = dk_reg;
        step_next   = step_reg;
        m_next      = m_reg;
        p_next      = p_reg;
        frac_next   = frac_reg;
        y_next      = y_reg;
        acc_next    = acc_reg;
        prod_next   = prod_reg;

        case (state_reg)
            // Take a transaction; calibration bookkeeping happens here
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next  = cmd;
                    raw_next  = raw_in;
                    done_next = 1'b0;
                    res_next  = '0;
                    if (cmd)
                    begin
                        if (cnt_add >= CNT_LAST)
                        begin
                            sum_next   = '0;
                            cnt_next   = '0;
                            done_next  = 1'b1;
                            num_next   = DIV_N_W'(sum_add);
                            state_next = S_AVG;
                        end
                        else
                        begin
                            sum_next   = sum_add;
                            cnt_next   = cnt_add;
                            state_next = S_FIN;
                        end
                    end
                    else if (raw_in == '0)
                    begin
                        state_next = S_FIN;
                    end
                    else
                    begin
                        val_next   = VAL_W'(raw_in);
                        state_next = S_RSMUL;
                    end
                end
            end

            // Batch average; a zero average keeps the reference
            S_AVG:
            begin
                if (avg_val == '0)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    val_next   = avg_val;
                    state_next = S_RSMUL;
                end
            end

            // Rs = (load * (full - v) << 8) / v
            S_RSMUL:
            begin
                num_next   = DIV_N_W'({rs_prod, 8'b0});
                dsr_next   = DIV_D_W'(val_reg);
                rem_next   = '0;
                step_next  = '0;
                dk_next    = DK_RS;
                state_next = S_DIV;
            end

            // Shared divider, one quotient bit a cycle
            S_DIV:
            begin
                rem_next  = q_bit ? rem_sh - {1'b0, dsr_reg} : rem_sh;
                num_next  = {num_reg[DIV_N_W-2:0], q_bit};
                step_next = step_reg + 6'd1;
                if (step_reg == DIV_LAST)
                begin
                    state_next = S_DVEND;
                end
            end

            // Dispatch the quotient
            S_DVEND:
            begin
                rem_next  = '0;
                step_next = '0;
                case (dk_reg)
                    DK_RS:
                    begin
                        if (cmd_reg)
                        begin
                            num_next = DIV_N_W'({q_sat, 8'b0});
                            dsr_next = DIV_D_W'(clean_reg);
                            dk_next  = DK_R0;
                        end
                        else
                        begin
                            num_next = {q_sat, 16'b0};
                            dsr_next = ref_reg;
                            dk_next  = DK_RATIO;
                        end
                        state_next = S_DIV;
                    end
                    DK_R0:
                    begin
                        ref_next   = q_sat;
                        state_next = S_FIN;
                    end
                    default:
                    begin
                        m_next     = (q_sat == '0) ? 32'd1 : q_sat;
                        p_next     = 5'd31;
                        state_next = S_NORM;
                    end
                endcase
            end

            // Normalise so that the leading one sits in bit 31
            S_NORM:
            begin
                if (m_reg[31])
                begin
                    frac_next  = '0;
                    step_next  = '0;
                    state_next = S_LOG;
                end
                else
                begin
                    m_next = {m_reg[30:0], 1'b0};
                    p_next = p_reg - 5'd1;
                end
            end

            // Fraction bits of log2 by repeated squaring
            S_LOG:
            begin
                if (sq_t[32])
                begin
                    m_next    = sq_t[32:1];
                    frac_next = {frac_reg[14:0], 1'b1};
                end
                else
                begin
                    m_next    = sq_t[31:0];
                    frac_next = {frac_reg[14:0], 1'b0};
                end
                step_next = step_reg + 6'd1;
                if (step_reg == ITER_LAST)
                begin
                    state_next = S_YMUL;
                end
            end

            // y = floor(log2 * exponent / 4096)
            S_YMUL:
            begin
                y_next     = 25'(ye_prod >>> 12);
                acc_next   = 31'd1 << 30;
                step_next  = '0;
                state_next = S_EXP;
            end

            // 2^fraction, most significant fraction bit first
            S_EXP:
            begin
                if (f_bits[~step_reg[3:0]])
                begin
                    acc_next = root_prod[60:30];
                end
                step_next = step_reg + 6'd1;
                if (step_reg == ITER_LAST)
                begin
                    state_next = S_SCALE;
                end
            end

            S_SCALE:
            begin
                prod_next  = scale_reg * acc_reg;
                state_next = S_SHIFT;
            end

            // Apply the integer part and saturate
            S_SHIFT:
            begin
                if (sh >= 10'sd64)
                begin
                    res_next = '0;
                end
                else if (sh < 10'sd0)
                begin
                    res_next = (prod_reg == '0) ? 16'd0 : 16'hFFFF;
                end
                else
                begin
                    res_next = (|shifted[54:16]) ? 16'hFFFF : shifted[15:0];
                end
                state_next = S_FIN;
            end

            S_FIN:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output register
    always_comb
    begin
        ovalid_next = ovalid_reg && out_stall;
        oraw_next   = oraw_reg;
        oppm_next   = oppm_reg;
        odone_next  = odone_reg;
        oref_next   = oref_reg;
        if (out_load)
        begin
            ovalid_next = 1'b1;
            oraw_next   = raw_reg;
            oppm_next   = res_reg;
            odone_next  = done_reg;
            oref_next   = ref_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            sum_reg    <= '0;
            cnt_reg    <= '0;
            ref_reg    <= gspc_pkg::REF_RESET;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            sum_reg    <= sum_next;
            cnt_reg    <= cnt_next;
            ref_reg    <= ref_next;
            ovalid_reg <= ovalid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        raw_reg   <= raw_next;
        val_reg   <= val_next;
        done_reg  <= done_next;
        res_reg   <= res_next;
        num_reg   <= num_next;
        rem_reg   <= rem_next;
        dsr_reg   <= dsr_next;
        dk_reg    <= dk_next;
        step_reg  <= step_next;
        m_reg     <= m_next;
        p_reg     <= p_next;
        frac_reg  <= frac_next;
        y_reg     <= y_next;
        acc_reg   <= acc_next;
        prod_reg  <= prod_next;
        oraw_reg  <= oraw_next;
        oppm_reg  <= oppm_next;
        odone_reg <= odone_next;
        oref_reg  <= oref_next;
    end

    assign in_stall         = (state_reg != S_IDLE);
    assign out_valid        = ovalid_reg;
    assign raw_out          = oraw_reg;
    assign ppm              = oppm_reg;
    assign calibration_done = odone_reg;
    assign reference_q16    = oref_reg;

endmodule

>>> src/gspc_checker.sv
// Port-level checker for the gas sensor block, bound to the top level
`include "gas_sensor_ppm_calibrated_top_macros.svh"

module gspc_checker #(
    parameter int ADC_BITS = gspc_pkg::ADC_BITS_DEF
) (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_stall,
    input logic                out_valid,
    input logic                out_stall,
    input logic [ADC_BITS-1:0] raw_out,
    input logic [15:0]         ppm,
    input logic                calibration_done
);

    // A result held back by the receiver stays offered
    `GSPC_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid, "output transaction dropped while stalled")

    // The block reports busy in the cycle after it accepts an item
    `GSPC_ASSERT_NXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "block not busy after accepting a transaction")

    // Calibration results carry no concentration
    `GSPC_ASSERT_IMP(a_cal_ppm_zero, out_valid && calibration_done, ppm == 16'd0, "nonzero ppm on batch completion")

    // A zero reading gives zero ppm
    `GSPC_ASSERT_IMP(a_raw_zero_ppm, out_valid && raw_out == '0, ppm == 16'd0, "nonzero ppm for zero reading")

endmodule

bind gas_sensor_ppm_calibrated_top gspc_checker #(.ADC_BITS(ADC_BITS)) u_gspc_checker (.*);

>>> dv/tb_gas_sensor_ppm_calibrated_top.sv
// Self-checking testbench for the gas sensor power-law ppm block
`timescale 1ns / 100ps

module tb_gas_sensor_ppm_calibrated_top;

    localparam int BATCH      = gspc_pkg::BATCH_LEN_DEF;
    localparam int FULL_SCALE = 4095;
    localparam int IDLE_LIMIT = 20000;

    typedef struct packed {
        logic [11:0] raw;
        logic [15:0] ppm;
        logic        done;
        logic [31:0] ref_q16;
    } reading_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [gspc_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [gspc_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        cmd = 1'b0;
    logic [11:0] sample = '0;
    logic        conversion_ok = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [11:0] raw_out;
    logic [15:0] ppm;
    logic        calibration_done;
    logic [31:0] reference_q16;

    gas_sensor_ppm_calibrated_top dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall), .cmd(cmd), .sample(sample),
        .conversion_ok(conversion_ok),
        .out_valid(out_valid), .out_stall(out_stall), .raw_out(raw_out), .ppm(ppm),
        .calibration_done(calibration_done), .reference_q16(reference_q16)
    );

    // Shadow registers and state of the predictor
    logic [15:0] load_q8;
    logic [23:0] scale_q8;
    logic [15:0] expo_q12;
    logic [15:0] clean_q8;
    logic [17:0] cal_sum;
    logic [5:0]  cal_count;
    logic [31:0] r0_q16;

    reading_t pending_readings[$];
    int       fail_count = 0;
    int       burst_left = 1;

    initial
    begin
        forever #6 clk = ~clk;
    end

    function automatic logic [31:0] sat32(logic [63:0] v);
        return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
    endfunction

    // Sensor resistance in Q16.16 kilo-ohms
    function automatic logic [31:0] sensor_kohm(logic [11:0] raw);
        logic [63:0] num;
        if (raw == 0 || raw >= FULL_SCALE)
            return 32'd0;
        num = (64'(load_q8) * 64'(FULL_SCALE - raw)) << 8;
        return sat32(num / 64'(raw));
    endfunction

    function automatic logic [63:0] int_root(logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] r;
        logic [63:0] b;
        v = v_in;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    // log2 of a Q16.16 value by repeated squaring
    function automatic longint log2_fix(logic [31:0] x);
        int          p;
        logic [63:0] m;
        longint      frac;
        p = 31;
        frac = 0;
        while (p > 0 && !x[p])
            p--;
        m = 64'(x) << (31 - p);
        for (int k = 0; k < 16; k++)
        begin
            m = (m * m) >> 31;
            frac = frac * 2;
            if (m >= (64'd1 << 32))
            begin
                frac = frac + 1;
                m = m >> 1;
            end
        end
        return longint'(p - 16) * 65536 + frac;
    endfunction

    function automatic longint floor_quot(longint y, longint d);
        if (y >= 0)
            return y / d;
        return -((-y + d - 1) / d);
    endfunction

    // scale * ratio^exponent, truncated and saturated
    function automatic logic [15:0] curve_ppm(logic [31:0] ratio);
        longint      e;
        longint      y;
        longint      ip;
        longint      f;
        longint      shift;
        logic [63:0] acc;
        logic [63:0] r;
        logic [63:0] prod;
        e = longint'($signed(expo_q12));
        acc = 64'd1 << 30;
        r = 64'd1 << 31;
        if (ratio == 0)
            ratio = 1;
        y = floor_quot(log2_fix(ratio) * e, 4096);
        ip = floor_quot(y, 65536);
        f = y - ip * 65536;
        for (int k = 15; k >= 0; k--)
        begin
            r = int_root(r << 30);
            if (((f >>> k) & 1) != 0)
                acc = (acc * r) >> 30;
        end
        prod = 64'(scale_q8) * acc;
        shift = 38 - ip;
        if (shift >= 64)
            return 16'd0;
        if (shift < 0)
            return (prod == 0) ? 16'd0 : 16'hFFFF;
        prod = prod >> shift;
        return (prod > 65535) ? 16'hFFFF : prod[15:0];
    endfunction

    // Advance the predictor by one accepted transaction
    function automatic reading_t predict_reading(logic c, logic [11:0] s, logic ok);
        reading_t    rd;
        logic [11:0] raw;
        logic [17:0] avg;
        logic [63:0] rs;
        logic [31:0] ratio;
        raw = ok ? s : 12'd0;
        rd.ppm = 16'd0;
        rd.done = 1'b0;
        if (c)
        begin
            cal_sum = cal_sum + 18'(raw);
            cal_count = cal_count + 6'd1;
            if (cal_count >= BATCH)
            begin
                avg = cal_sum / BATCH;
                if (avg != 0)
                begin
                    rs = 64'(sensor_kohm(avg[11:0]));
                    r0_q16 = (clean_q8 == 0) ? 32'hFFFF_FFFF
                           : sat32((rs << 8) / 64'(clean_q8));
                end
                cal_sum = 0;
                cal_count = 0;
                rd.done = 1'b1;
            end
        end
        else if (raw != 0)
        begin
            rs = 64'(sensor_kohm(raw));
            ratio = (r0_q16 == 0) ? 32'hFFFF_FFFF : sat32((rs << 16) / 64'(r0_q16));
            rd.ppm = curve_ppm(ratio);
        end
        rd.raw = raw;
        rd.ref_q16 = r0_q16;
        return rd;
    endfunction

    task automatic report_mismatch(string field, longint got, longint want);
        $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, field, got, want);
        fail_count++;
    endtask

    // Send one transaction; the sender works in bursts with gaps between
    task automatic send_sample(logic c, logic [11:0] s, logic ok);
        in_valid <= 1'b1;
        cmd <= c;
        sample <= s;
        conversion_ok <= ok;
        do
            @(posedge clk);
        while (in_stall);
        pending_readings.push_back(predict_reading(c, s, ok));
        burst_left--;
        if (burst_left <= 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 10);
        end
    endtask

    // Hold off the sender until every result has come back
    task automatic drain;
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_readings.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic cfg_write(logic [gspc_pkg::CFG_IDX_W-1:0] idx,
                             logic [gspc_pkg::CFG_DATA_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        case (idx)
            gspc_pkg::CFG_LOAD:  load_q8 = val[15:0];
            gspc_pkg::CFG_SCALE: scale_q8 = val;
            gspc_pkg::CFG_EXP:   expo_q12 = val[15:0];
            gspc_pkg::CFG_CLEAN: clean_q8 = val[15:0];
            default: ;
        endcase
    endtask

    // Block must be idle before this is called
    task automatic program_curve(logic [15:0] ld, logic [23:0] sc, logic [15:0] ex,
                                 logic [15:0] cl);
        cfg_write(gspc_pkg::CFG_LOAD, 24'(ld));
        cfg_write(gspc_pkg::CFG_SCALE, sc);
        cfg_write(gspc_pkg::CFG_EXP, 24'(ex));
        cfg_write(gspc_pkg::CFG_CLEAN, 24'(cl));
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [11:0] pick_sample();
        case ($urandom_range(0, 9))
            0: return 12'd0;
            1: return 12'd4095;
            2: return 12'd4094;
            3: return 12'd1;
            4: return 12'($urandom_range(1, 40));
            default: return 12'($urandom);
        endcase
    endfunction

    task automatic run_batch(logic [11:0] s, logic ok);
        for (int i = 0; i < BATCH; i++)
            send_sample(1'b1, s, ok);
    endtask

    // Reset registers: reading extremes, failed conversion, both commands
    task automatic test_default_curve;
        send_sample(1'b0, 12'd0, 1'b1);
        send_sample(1'b0, 12'd1, 1'b1);
        send_sample(1'b0, 12'd4095, 1'b1);
        send_sample(1'b0, 12'd4094, 1'b1);
        send_sample(1'b0, 12'd2048, 1'b1);
        send_sample(1'b0, 12'd2730, 1'b0);
        send_sample(1'b0, 12'd1365, 1'b1);
        send_sample(1'b1, 12'd4095, 1'b1);
        send_sample(1'b1, 12'd0, 1'b1);
        send_sample(1'b1, 12'd1234, 1'b0);
        send_sample(1'b0, 12'd777, 1'b1);
        drain();
    endtask

    // Clean-air batch then measures; a batch of failed conversions keeps r0
    task automatic test_calibration;
        run_batch(12'd1800, 1'b1);
        send_sample(1'b0, 12'd1800, 1'b1);
        send_sample(1'b0, 12'd600, 1'b1);
        run_batch(12'd3000, 1'b0);
        send_sample(1'b0, 12'd600, 1'b1);
        drain();
    endtask

    // Register extremes, reference zero and clean ratio zero
    task automatic test_register_extremes;
        program_curve(16'd65535, 24'hFFFFFF, 16'h7FFF, 16'd1);
        send_sample(1'b0, 12'd1, 1'b1);
        send_sample(1'b0, 12'd4094, 1'b1);
        send_sample(1'b0, 12'd100, 1'b1);
        drain();
        program_curve(16'd1, 24'd0, 16'h8000, 16'd65535);
        send_sample(1'b0, 12'd1, 1'b1);
        send_sample(1'b0, 12'd3000, 1'b1);
        // tiny load and huge clean ratio drive r0 to zero
        run_batch(12'd4094, 1'b1);
        drain();
        program_curve(16'd2560, 24'd28280, 16'h8000, 16'd922);
        send_sample(1'b0, 12'd2000, 1'b1);
        send_sample(1'b0, 12'd4094, 1'b1);
        drain();
        program_curve(16'd2560, 24'd28280, 16'd0, 16'd0);
        run_batch(12'd2000, 1'b1);
        send_sample(1'b0, 12'd2000, 1'b1);
        send_sample(1'b0, 12'd5, 1'b1);
        drain();
    endtask

    // Random transactions across several register settings
    task automatic test_random_traffic;
        for (int phase = 0; phase < 6; phase++)
        begin
            if (phase % 2 == 0)
                program_curve(16'($urandom_range(1280, 5120)), 24'($urandom_range(5000, 60000)),
                              16'(-$urandom_range(2000, 16000)), 16'($urandom_range(256, 1280)));
            else
                program_curve(16'($urandom_range(1, 65535)), 24'($urandom),
                              16'($urandom), 16'($urandom_range(1, 65535)));
            for (int i = 0; i < 240; i++)
                send_sample($urandom_range(0, 99) < 40, pick_sample(),
                            $urandom_range(0, 15) != 0);
            drain();
        end
    endtask

    // Compare each result with the oldest prediction
    always @(posedge clk)
    begin
        reading_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_readings.size() == 0)
            begin
                $display("%0t: result with nothing pending", $realtime);
                fail_count++;
            end
            else
            begin
                want = pending_readings.pop_front();
                if (raw_out !== want.raw)
                    report_mismatch("raw_out", raw_out, want.raw);
                if (ppm !== want.ppm)
                    report_mismatch("ppm", ppm, want.ppm);
                if (calibration_done !== want.done)
                    report_mismatch("calibration_done", calibration_done, want.done);
                if (reference_q16 !== want.ref_q16)
                    report_mismatch("reference_q16", reference_q16, want.ref_q16);
            end
        end
    end

    // Receiver stall pattern: random stretches, some long ones without stalls
    int  stall_run = 0;
    logic stall_lvl = 1'b0;
    always @(posedge clk)
    begin
        if (stall_run == 0)
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                stall_lvl = 1'b0;
                stall_run = $urandom_range(50, 300);
            end
            else
            begin
                stall_lvl = ($urandom_range(0, 2) == 0);
                stall_run = $urandom_range(1, 20);
            end
        end
        stall_run--;
        out_stall <= stall_lvl;
    end

    // Watchdog on cycles with no transaction on either channel
    int idle_cycles = 0;
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        load_q8 = gspc_pkg::LOAD_RESET;
        scale_q8 = gspc_pkg::SCALE_RESET;
        expo_q12 = gspc_pkg::EXP_RESET;
        clean_q8 = gspc_pkg::CLEAN_RESET;
        cal_sum = 0;
        cal_count = 0;
        r0_q16 = gspc_pkg::REF_RESET;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_default_curve();
        test_calibration();
        test_register_extremes();
        test_random_traffic();
        drain();
        repeat (200) @(posedge clk);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
